FILE: sv/lld_pkg.sv
// Package for the least-loaded job dispatcher.
// Holds command codes, limits, sequencer states and the scan control struct.
// No dependencies.
`timescale 1ns / 1ps

package lld_pkg;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned SIDX_W  = 4;
   localparam int unsigned VAL_W   = 7;
   localparam int unsigned CNT_W   = 5;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned PROD_W  = 2 * VAL_W;

   localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_REJ = 1'b1;

   localparam logic [VAL_W-1:0]  VALUE_MIN   = 7'd1;
   localparam logic [VAL_W-1:0]  VALUE_LIMIT = 7'd100;
   localparam logic [VAL_W-1:0]  RATE_RESET  = 7'd1;
   localparam logic [CNT_W-1:0]  COUNT_RESET = 5'd16;
   localparam logic [TIME_W-1:0] TIME_MAX    = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SCAN,
      ST_DRAIN,
      ST_RATE,
      ST_MUL,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic vld;
      logic first;
   } scan_ctl_type;

   function automatic logic in_range(input logic [VAL_W-1:0] v);
      return (v >= VALUE_MIN) && (v <= VALUE_LIMIT);
   endfunction

endpackage

FILE: sv/least_loaded_job_dispatcher_core.sv
// Top level of the least-loaded job dispatcher: sequencer, free-time and rate memories.
// Depends on lld_pkg and lld_min_scan.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Each request gives one result,
// shown for exactly one cycle with rsp_valid high; the receiver cannot stall it. A rate
// load, an invalid command or a rejected dispatch gives its result in the cycle after the
// request. For a dispatch the free-time memory is read one server per cycle, over the
// enabled servers, into a single compare unit, then the rate is read, multiplied and
// added. A clear writes one free-time entry per cycle before its result. After reset
// the memories are swept with busy high; csr writes are taken at any time.
module least_loaded_job_dispatcher_core #(
   parameter int unsigned MAX_SERVERS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lld_pkg::CMD_W-1:0]           req_command,
   input  logic [lld_pkg::SIDX_W-1:0]          req_server_index,
   input  logic [lld_pkg::VAL_W-1:0]           req_service_rate,
   input  logic [lld_pkg::VAL_W-1:0]           req_job_items,
   input  logic                                csr_write_en,
   input  logic [lld_pkg::CNT_W-1:0]           csr_write_data,
   output logic                                rsp_valid,
   output logic                                rsp_status,
   output logic [lld_pkg::SIDX_W-1:0]          rsp_chosen_server,
   output logic [lld_pkg::TIME_W-1:0]          rsp_start_time,
   output logic [lld_pkg::TIME_W-1:0]          rsp_finish_time,
   output logic [lld_pkg::TIME_W-1:0]          rsp_makespan
);

   localparam int unsigned IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam logic [IW-1:0] PTR_END = IW'(MAX_SERVERS - 1);

   lld_pkg::state_type state_ff, state_in;
   logic                         init_ff, init_in;
   logic [IW-1:0]                ptr_ff, ptr_in;
   logic [lld_pkg::CNT_W-1:0]    csr_ff;
   logic [lld_pkg::TIME_W-1:0]   longest_ff, longest_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         cmp_vld_ff;
   logic [IW-1:0]                cmp_idx_ff;
   logic [lld_pkg::VAL_W-1:0]    items_ff, items_in;
   logic [lld_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic [lld_pkg::SIDX_W-1:0]   rsp_chosen_ff, rsp_chosen_in;
   logic [lld_pkg::TIME_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [lld_pkg::TIME_W-1:0]   rsp_finish_ff, rsp_finish_in;
   logic [lld_pkg::TIME_W-1:0]   rsp_makespan_ff, rsp_makespan_in;

   logic [lld_pkg::TIME_W-1:0]   time_mem [MAX_SERVERS];
   logic [lld_pkg::VAL_W-1:0]    rate_mem [MAX_SERVERS];
   logic [lld_pkg::TIME_W-1:0]   tm_rdata_ff;
   logic [lld_pkg::VAL_W-1:0]    rt_rdata_ff;
   logic                         tm_we, rt_we;
   logic [IW-1:0]                tm_waddr, rt_waddr;
   logic [lld_pkg::TIME_W-1:0]   tm_wdata;
   logic [lld_pkg::VAL_W-1:0]    rt_wdata;

   logic [IW-1:0]                last_idx;
   logic [IW-1:0]                load_idx;
   logic                         load_ok;
   logic [lld_pkg::TIME_W:0]     sum;
   logic [lld_pkg::TIME_W-1:0]   finish;
   lld_pkg::scan_ctl_type        scan_ctl;
   logic [IW-1:0]                best_idx;
   logic [lld_pkg::TIME_W-1:0]   best_time;

   always_comb begin
      priority if (csr_ff == '0) begin
         last_idx = '0;
      end else if (32'(csr_ff) > 32'(MAX_SERVERS)) begin
         last_idx = PTR_END;
      end else begin
         last_idx = IW'(csr_ff - 1'b1);
      end
   end

   assign load_idx = IW'(req_server_index);
   assign load_ok  = (32'(req_server_index) <= 32'(last_idx))
                     && lld_pkg::in_range(req_service_rate);
   assign sum      = {1'b0, best_time} + (lld_pkg::TIME_W + 1)'(prod_ff);
   assign finish   = sum[lld_pkg::TIME_W] ? lld_pkg::TIME_MAX : sum[lld_pkg::TIME_W-1:0];

   assign scan_ctl.vld   = cmp_vld_ff;
   assign scan_ctl.first = (cmp_idx_ff == '0);

   lld_min_scan #(
      .IW (IW)
   ) u_min_scan (
      .clock     (clock),
      .ctl       (scan_ctl),
      .idx       (cmp_idx_ff),
      .data      (tm_rdata_ff),
      .best_idx  (best_idx),
      .best_time (best_time)
   );

   always_comb begin
      state_in        = state_ff;
      init_in         = init_ff;
      ptr_in          = ptr_ff;
      longest_in      = longest_ff;
      items_in        = items_ff;
      prod_in         = prod_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = lld_pkg::STATUS_REJ;
      rsp_chosen_in   = '0;
      rsp_start_in    = '0;
      rsp_finish_in   = '0;
      rsp_makespan_in = longest_ff;
      tm_we           = 1'b0;
      tm_waddr        = ptr_ff;
      tm_wdata        = '0;
      rt_we           = 1'b0;
      rt_waddr        = ptr_ff;
      rt_wdata        = lld_pkg::RATE_RESET;
      unique case (state_ff)
         lld_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_command)
                  lld_pkg::CMD_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (load_ok) begin
                        rsp_status_in = lld_pkg::STATUS_OK;
                        tm_we         = 1'b1;
                        tm_waddr      = load_idx;
                        rt_we         = 1'b1;
                        rt_waddr      = load_idx;
                        rt_wdata      = req_service_rate;
                     end
                  end
                  lld_pkg::CMD_DISPATCH: begin
                     if (lld_pkg::in_range(req_job_items)) begin
                        items_in = req_job_items;
                        ptr_in   = '0;
                        state_in = lld_pkg::ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  lld_pkg::CMD_CLEAR: begin
                     ptr_in   = '0;
                     init_in  = 1'b0;
                     state_in = lld_pkg::ST_SWEEP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         lld_pkg::ST_SWEEP: begin
            tm_we = 1'b1;
            rt_we = init_ff;
            if (ptr_ff == PTR_END) begin
               longest_in      = '0;
               init_in         = 1'b0;
               state_in        = lld_pkg::ST_IDLE;
               rsp_valid_in    = !init_ff;
               rsp_status_in   = lld_pkg::STATUS_OK;
               rsp_makespan_in = '0;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         lld_pkg::ST_SCAN: begin
            if (ptr_ff == last_idx) begin
               state_in = lld_pkg::ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         lld_pkg::ST_DRAIN: begin
            state_in = lld_pkg::ST_RATE;
         end
         lld_pkg::ST_RATE: begin
            state_in = lld_pkg::ST_MUL;
         end
         lld_pkg::ST_MUL: begin
            prod_in  = lld_pkg::PROD_W'(items_ff) * lld_pkg::PROD_W'(rt_rdata_ff);
            state_in = lld_pkg::ST_FIN;
         end
         lld_pkg::ST_FIN: begin
            tm_we           = 1'b1;
            tm_waddr        = best_idx;
            tm_wdata        = finish;
            longest_in      = (finish > longest_ff) ? finish : longest_ff;
            rsp_valid_in    = 1'b1;
            rsp_status_in   = lld_pkg::STATUS_OK;
            rsp_chosen_in   = lld_pkg::SIDX_W'(best_idx);
            rsp_start_in    = best_time;
            rsp_finish_in   = finish;
            rsp_makespan_in = (finish > longest_ff) ? finish : longest_ff;
            state_in        = lld_pkg::ST_IDLE;
         end
         default: begin
            state_in = lld_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lld_pkg::ST_SWEEP;
         init_ff      <= 1'b1;
         ptr_ff       <= '0;
         csr_ff       <= lld_pkg::COUNT_RESET;
         longest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         ptr_ff       <= ptr_in;
         longest_ff   <= longest_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= (state_ff == lld_pkg::ST_SCAN);
         if (csr_write_en) begin
            csr_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff      <= ptr_ff;
      items_ff        <= items_in;
      prod_ff         <= prod_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_chosen_ff   <= rsp_chosen_in;
      rsp_start_ff    <= rsp_start_in;
      rsp_finish_ff   <= rsp_finish_in;
      rsp_makespan_ff <= rsp_makespan_in;
   end

   always_ff @(posedge clock) begin
      if (tm_we) begin
         time_mem[tm_waddr] <= tm_wdata;
      end
      tm_rdata_ff <= time_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (rt_we) begin
         rate_mem[rt_waddr] <= rt_wdata;
      end
      rt_rdata_ff <= rate_mem[best_idx];
   end

   assign busy              = (state_ff != lld_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_chosen_server = rsp_chosen_ff;
   assign rsp_start_time    = rsp_start_ff;
   assign rsp_finish_time   = rsp_finish_ff;
   assign rsp_makespan      = rsp_makespan_ff;

endmodule

FILE: sv/lld_min_scan.sv
// Running minimum unit: one free-time compare per cycle, lowest index wins ties.
// Depends on lld_pkg.
`timescale 1ns / 1ps

module lld_min_scan #(
   parameter int unsigned IW = 4
) (
   input  logic                        clock,
   input  lld_pkg::scan_ctl_type       ctl,
   input  logic [IW-1:0]               idx,
   input  logic [lld_pkg::TIME_W-1:0]  data,
   output logic [IW-1:0]               best_idx,
   output logic [lld_pkg::TIME_W-1:0]  best_time
);

   logic [IW-1:0]              best_idx_ff;
   logic [lld_pkg::TIME_W-1:0] best_time_ff;

   always_ff @(posedge clock) begin
      if (ctl.vld && (ctl.first || (data < best_time_ff))) begin
         best_idx_ff  <= idx;
         best_time_ff <= data;
      end
   end

   assign best_idx  = best_idx_ff;
   assign best_time = best_time_ff;

endmodule

FILE: verif/least_loaded_job_dispatcher_core_test.sv
// Self-checking testbench for least_loaded_job_dispatcher_core: directed and random requests,
// server count changes while idle, every result checked against a mirror of the server bank.
// Depends on lld_pkg and the dispatcher RTL.
`timescale 1ns / 1ps

typedef struct {
   logic                             status;
   logic [lld_pkg::SIDX_W-1:0]       chosen;
   logic [lld_pkg::TIME_W-1:0]       begin_at;
   logic [lld_pkg::TIME_W-1:0]       end_at;
   logic [lld_pkg::TIME_W-1:0]       span;
} dispatch_outcome_type;

class server_bank_mirror;
   logic [lld_pkg::TIME_W-1:0]  free_at [16];
   logic [lld_pkg::VAL_W-1:0]   unit_cost [16];
   logic [lld_pkg::TIME_W-1:0]  longest;
   logic [lld_pkg::CNT_W-1:0]   server_count;
   dispatch_outcome_type        owed [$];
   int unsigned                 failures;

   function new();
      foreach (free_at[i]) begin
         free_at[i]   = '0;
         unit_cost[i] = lld_pkg::RATE_RESET;
      end
      longest      = '0;
      server_count = lld_pkg::COUNT_RESET;
      failures     = 0;
   endfunction

   function void set_server_count(input logic [lld_pkg::CNT_W-1:0] v);
      server_count = v;
   endfunction

   function bit value_ok(input logic [lld_pkg::VAL_W-1:0] v);
      return (v >= lld_pkg::VALUE_MIN) && (v <= lld_pkg::VALUE_LIMIT);
   endfunction

   function void apply_request(input logic [lld_pkg::CMD_W-1:0] cmd,
                               input logic [lld_pkg::SIDX_W-1:0] idx,
                               input logic [lld_pkg::VAL_W-1:0] cost,
                               input logic [lld_pkg::VAL_W-1:0] items);
      dispatch_outcome_type o;
      int unsigned     active;
      int unsigned     best;
      logic [63:0]     total;
      o.status   = lld_pkg::STATUS_REJ;
      o.chosen   = '0;
      o.begin_at = '0;
      o.end_at   = '0;
      active = (server_count == 0) ? 1 : ((server_count > 16) ? 16 : server_count);
      case (cmd)
         lld_pkg::CMD_LOAD: begin
            if (idx < active && value_ok(cost)) begin
               unit_cost[idx] = cost;
               free_at[idx]   = '0;
               o.status       = lld_pkg::STATUS_OK;
            end
         end
         lld_pkg::CMD_DISPATCH: begin
            if (value_ok(items)) begin
               best = 0;
               for (int unsigned i = 1; i < active; i++) begin
                  if (free_at[i] < free_at[best]) best = i;
               end
               total = {32'd0, free_at[best]} + 64'(items) * 64'(unit_cost[best]);
               if (total > {32'd0, lld_pkg::TIME_MAX}) total = {32'd0, lld_pkg::TIME_MAX};
               o.begin_at    = free_at[best];
               o.end_at      = total[31:0];
               o.chosen      = best[3:0];
               o.status      = lld_pkg::STATUS_OK;
               free_at[best] = total[31:0];
               if (total[31:0] > longest) longest = total[31:0];
            end
         end
         lld_pkg::CMD_CLEAR: begin
            foreach (free_at[i]) free_at[i] = '0;
            longest  = '0;
            o.status = lld_pkg::STATUS_OK;
         end
         default: ;
      endcase
      o.span = longest;
      owed.push_back(o);
   endfunction

   function void compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   function void match_result(input logic status, input logic [lld_pkg::SIDX_W-1:0] chosen,
                              input logic [31:0] begin_at, input logic [31:0] end_at,
                              input logic [31:0] span);
      dispatch_outcome_type o;
      if (owed.size() == 0) begin
         failures++;
         $display("%0t: result with no request outstanding", $time);
         return;
      end
      o = owed.pop_front();
      compare_field("status", 32'(o.status), 32'(status));
      compare_field("chosen_server", 32'(o.chosen), 32'(chosen));
      compare_field("start_time", o.begin_at, begin_at);
      compare_field("finish_time", o.end_at, end_at);
      compare_field("makespan", o.span, span);
   endfunction
endclass

module least_loaded_job_dispatcher_core_test;

   localparam int unsigned               SERVERS      = 16;
   localparam logic [lld_pkg::CMD_W-1:0] CMD_UNUSED   = 2'd3;
   localparam int unsigned               DRAIN_CYCLES = SERVERS + 8;
   localparam int unsigned               CYCLE_LIMIT  = 400000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [lld_pkg::CMD_W-1:0]    req_command = '0;
   logic [lld_pkg::SIDX_W-1:0]   req_server_index = '0;
   logic [lld_pkg::VAL_W-1:0]    req_service_rate = '0;
   logic [lld_pkg::VAL_W-1:0]    req_job_items = '0;
   logic                         csr_write_en = 1'b0;
   logic [lld_pkg::CNT_W-1:0]    csr_write_data = '0;
   logic                         rsp_valid;
   logic                         rsp_status;
   logic [lld_pkg::SIDX_W-1:0]   rsp_chosen_server;
   logic [lld_pkg::TIME_W-1:0]   rsp_start_time;
   logic [lld_pkg::TIME_W-1:0]   rsp_finish_time;
   logic [lld_pkg::TIME_W-1:0]   rsp_makespan;

   server_bank_mirror            bank = new();
   logic [lld_pkg::CNT_W-1:0]    count_now = lld_pkg::COUNT_RESET;
   int unsigned                  cycles = 0;

   least_loaded_job_dispatcher_core #(.MAX_SERVERS(SERVERS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_server_index(req_server_index),
      .req_service_rate(req_service_rate), .req_job_items(req_job_items),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_chosen_server(rsp_chosen_server),
      .rsp_start_time(rsp_start_time), .rsp_finish_time(rsp_finish_time),
      .rsp_makespan(rsp_makespan)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            bank.match_result(rsp_status, rsp_chosen_server, rsp_start_time,
                              rsp_finish_time, rsp_makespan);
         if (csr_write_en) bank.set_server_count(csr_write_data);
         if (start && !busy)
            bank.apply_request(req_command, req_server_index, req_service_rate,
                               req_job_items);
      end
   end

   task automatic push_request(input logic [lld_pkg::CMD_W-1:0] cmd,
                               input logic [lld_pkg::SIDX_W-1:0] idx,
                               input logic [lld_pkg::VAL_W-1:0] cost,
                               input logic [lld_pkg::VAL_W-1:0] items);
      @(negedge clock);
      start            = 1'b1;
      req_command      = cmd;
      req_server_index = idx;
      req_service_rate = cost;
      req_job_items    = items;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int unsigned n);
      @(negedge clock);
      start = 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic quiesce();
      @(negedge clock);
      start = 1'b0;
      while (bank.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [lld_pkg::CNT_W-1:0] v);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_en   = 1'b0;
      count_now      = v;
   endtask

   task automatic random_phase(input int unsigned total);
      int unsigned                sent;
      int unsigned                burst;
      int unsigned                pick;
      int unsigned                active;
      logic [lld_pkg::CMD_W-1:0]  cmd;
      logic [lld_pkg::SIDX_W-1:0] idx;
      logic [lld_pkg::VAL_W-1:0]  cost;
      logic [lld_pkg::VAL_W-1:0]  items;
      sent   = 0;
      active = (count_now == 0) ? 1 : ((count_now > SERVERS) ? SERVERS : count_now);
      while (sent < total) begin
         burst = $urandom_range(1, 24);
         for (int unsigned k = 0; k < burst && sent < total; k++) begin
            pick  = $urandom_range(0, 99);
            idx   = 4'($urandom_range(0, 15));
            cost  = 7'($urandom_range(1, 100));
            items = 7'($urandom_range(1, 100));
            if (pick < 55) begin
               cmd = lld_pkg::CMD_DISPATCH;
               if ($urandom_range(0, 3) == 0) items = 7'($urandom_range(1, 5));
            end else if (pick < 80) begin
               cmd = lld_pkg::CMD_LOAD;
               if ($urandom_range(0, 3) != 0) idx = 4'($urandom_range(0, active - 1));
            end else if (pick < 84) begin
               cmd = lld_pkg::CMD_CLEAR;
            end else if (pick < 88) begin
               cmd = CMD_UNUSED;
            end else begin
               cmd   = 2'($urandom_range(0, 3));
               cost  = 7'($urandom_range(0, 127));
               items = 7'($urandom_range(0, 127));
            end
            push_request(cmd, idx, cost, items);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      end
   endtask

   initial begin
      logic [lld_pkg::CNT_W-1:0] counts [6];
      counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_request(lld_pkg::CMD_DISPATCH, 4'd0, 7'd0, 7'd1);
      push_request(lld_pkg::CMD_DISPATCH, 4'd9, 7'd127, 7'd100);
      push_request(lld_pkg::CMD_LOAD, 4'd15, 7'd100, 7'd0);
      push_request(lld_pkg::CMD_LOAD, 4'd3, 7'd0, 7'd127);
      push_request(lld_pkg::CMD_LOAD, 4'd4, 7'd101, 7'd5);
      push_request(lld_pkg::CMD_LOAD, 4'd5, 7'd127, 7'd5);
      push_request(lld_pkg::CMD_LOAD, 4'd2, 7'd1, 7'd5);
      push_request(lld_pkg::CMD_DISPATCH, 4'd0, 7'd5, 7'd0);
      push_request(lld_pkg::CMD_DISPATCH, 4'd0, 7'd5, 7'd101);
      push_request(lld_pkg::CMD_DISPATCH, 4'd15, 7'd5, 7'd127);
      push_request(CMD_UNUSED, 4'd15, 7'd127, 7'd127);
      push_request(lld_pkg::CMD_CLEAR, 4'd0, 7'd0, 7'd0);
      push_request(lld_pkg::CMD_DISPATCH, 4'd0, 7'd0, 7'd100);
      quiesce();
      write_count(5'd3);
      push_request(lld_pkg::CMD_LOAD, 4'd3, 7'd50, 7'd1);
      push_request(lld_pkg::CMD_LOAD, 4'd2, 7'd100, 7'd1);
      repeat (4) push_request(lld_pkg::CMD_DISPATCH, 4'd0, 7'd1, 7'd100);
      quiesce();
      write_count(5'd0);
      push_request(lld_pkg::CMD_DISPATCH, 4'd0, 7'd1, 7'd60);
      push_request(lld_pkg::CMD_DISPATCH, 4'd0, 7'd1, 7'd60);
      push_request(lld_pkg::CMD_LOAD, 4'd1, 7'd10, 7'd1);
      quiesce();
      write_count(5'd31);
      push_request(lld_pkg::CMD_LOAD, 4'd15, 7'd7, 7'd1);
      push_request(lld_pkg::CMD_DISPATCH, 4'd0, 7'd1, 7'd30);
      quiesce();
      write_count(5'd17);
      push_request(lld_pkg::CMD_DISPATCH, 4'd0, 7'd1, 7'd30);

      for (int unsigned phase = 0; phase < 16; phase++) begin
         quiesce();
         write_count(phase < 6 ? counts[phase] : 5'($urandom_range(0, 31)));
         random_phase(102);
      end
      quiesce();

      if (bank.failures == 0 && bank.owed.size() == 0) begin
         $display("All tests passed");
      end else begin
         if (bank.owed.size() != 0)
            $display("%0t: %0d results never arrived", $time, bank.owed.size());
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

FILE: sim.f
sv/lld_pkg.sv
sv/lld_min_scan.sv
sv/least_loaded_job_dispatcher_core.sv
verif/least_loaded_job_dispatcher_core_test.sv
